>>> hdl/bffa_pkg.sv
`default_nettype none

package bffa_pkg;

	// field and register widths
	localparam int REQ_W      = 32;
	localparam int BS_W       = 17;
	localparam int NB_W       = 9;
	localparam int START_W    = 8;
	localparam int BYTE_W     = 8;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 17;

	// pool size default
	localparam int DEF_MAX_BLOCKS = 256;

	// register reset values
	localparam logic [BS_W-1:0] BS_RESET = 17'd256;
	localparam logic [NB_W-1:0] NB_RESET = 9'd256;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_BLOCKS = 8'd1;

	// restoring divider: 33-bit dividend, one quotient bit per step
	localparam int QUO_W     = REQ_W + 1;
	localparam int DIV_STEPS = QUO_W;
	localparam int DIV_CNT_W = 6;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic div_step;
		logic clr_we;
		logic scan_init;
		logic scan_ev;
		logic mark_init;
		logic mark_wr;
		logic set_ok;
		logic set_zero;
		logic set_fail;
		logic out_load;
	} bffa_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic div_last;
		logic need_zero;
		logic too_big;
		logic scan_hit;
		logic scan_last;
		logic mark_last;
	} bffa_stat_t;

endpackage

`default_nettype wire

>>> hdl/bffa_ram.sv
`default_nettype none

module bffa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [AW-1:0]        waddr,
	input  wire logic [WIDTH-1:0]     wdata,
	input  wire logic [AW-1:0]        raddr,
	output      logic [WIDTH-1:0]     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> hdl/bffa_div.sv
`default_nettype none

module bffa_div
	import bffa_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire logic              step,
	input  wire logic [QUO_W-1:0]  dividend,
	input  wire logic [BS_W-1:0]   divisor,
	output      logic [QUO_W-1:0]  quot,
	output      logic              last
);

	logic [BS_W-1:0]      rem_q;
	logic [QUO_W-1:0]     quo_q;
	logic [BS_W-1:0]      dsr_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [BS_W:0]        trial;
	logic                 ge;

	// trial subtract of the next dividend bit
	assign trial = {rem_q, quo_q[QUO_W-1]};
	assign ge    = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= '0;
		end else if (step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// dividend shifts out at the top while quotient bits shift in
	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (step) begin
			rem_q <= ge ? BS_W'(trial - {1'b0, dsr_q}) : BS_W'(trial);
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign quot = quo_q;
	assign last = cnt_q == DIV_CNT_W'(DIV_STEPS - 1);

endmodule

`default_nettype wire

>>> hdl/bffa_dp.sv
`default_nettype none

module bffa_dp
	import bffa_pkg::*;
#(
	parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire bffa_cmd_t             cmd,
	output      bffa_stat_t            stat,
	input  wire logic [REQ_W-1:0]      request_bytes,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output      logic                  success,
	output      logic [START_W-1:0]    start_block
);

	localparam int MAP_ROWS = (MAX_BLOCKS + BYTE_W - 1) / BYTE_W;
	localparam int ROW_W    = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
	localparam int BLK_W    = ROW_W + 3;
	localparam int CNT_W    = $clog2(MAX_BLOCKS + 1);

	logic [BS_W-1:0]   block_size_q;
	logic [NB_W-1:0]   num_blocks_q;
	logic [BS_W-1:0]   bs_eff;
	logic [CNT_W-1:0]  pool;
	logic [QUO_W-1:0]  quot;
	logic [CNT_W-1:0]  need;
	logic [ROW_W-1:0]  row_q;
	logic [CNT_W-1:0]  run_q;
	logic [CNT_W-1:0]  run_n;
	logic [BLK_W-1:0]  end_q;
	logic [BLK_W-1:0]  end_n;
	logic [BLK_W-1:0]  start;
	logic              hit;
	logic [BYTE_W-1:0] rdata;
	logic [BYTE_W-1:0] mask;
	logic [BYTE_W-1:0] wdata;
	logic              ram_we;
	logic              res_ok_q;
	logic [START_W-1:0] res_start_q;
	logic              success_q;
	logic [START_W-1:0] start_block_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q <= BS_RESET;
			num_blocks_q <= NB_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_BLOCK_SIZE) begin
				block_size_q <= cfg_data[BS_W-1:0];
			end else if (cfg_index == REG_NUM_BLOCKS) begin
				num_blocks_q <= cfg_data[NB_W-1:0];
			end
		end
	end

	// zero block size acts as one, pool clamps to the bitmap size
	assign bs_eff = (block_size_q == '0) ? BS_W'(1) : block_size_q;
	assign pool   = (32'(num_blocks_q) > 32'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
	                                                     : CNT_W'(num_blocks_q);

	// block count by rounding-up division
	bffa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (cmd.load),
		.step     (cmd.div_step),
		.dividend (QUO_W'({1'b0, request_bytes}) + QUO_W'(bs_eff) - QUO_W'(1)),
		.divisor  (bs_eff),
		.quot     (quot),
		.last     (stat.div_last)
	);

	assign need           = CNT_W'(quot);
	assign stat.need_zero = quot == '0;
	assign stat.too_big   = quot > QUO_W'(pool);

	// first-fit scan over one bitmap byte
	always_comb begin
		logic [BLK_W-1:0] idx;
		run_n = run_q;
		end_n = end_q;
		hit   = 1'b0;
		idx   = '0;
		for (int b = 0; b < BYTE_W; b++) begin
			idx = {row_q, 3'(b)};
			if (!hit && (32'(idx) < 32'(pool))) begin
				if (rdata[b]) begin
					run_n = '0;
				end else begin
					run_n = run_n + 1'b1;
					if (run_n == need) begin
						hit   = 1'b1;
						end_n = idx;
					end
				end
			end
		end
	end

	assign stat.scan_hit  = hit;
	assign stat.scan_last = (32'({row_q, 3'b000}) + 32'(BYTE_W)) >= 32'(pool);

	// run start and per-byte mark mask
	assign start = end_q + BLK_W'(1) - BLK_W'(need);

	always_comb begin
		logic [BLK_W-1:0] idx;
		mask = '0;
		idx  = '0;
		for (int b = 0; b < BYTE_W; b++) begin
			idx     = {row_q, 3'(b)};
			mask[b] = (idx >= start) && (idx <= end_q);
		end
	end

	assign stat.mark_last = row_q == end_q[BLK_W-1:3];
	assign stat.clr_last  = row_q == ROW_W'(MAP_ROWS - 1);

	// row pointer, run length and run end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			run_q <= '0;
			end_q <= '0;
		end else begin
			if (cmd.clr_we || cmd.mark_wr) begin
				row_q <= row_q + 1'b1;
			end else if (cmd.scan_init) begin
				row_q <= '0;
			end else if (cmd.scan_ev) begin
				row_q <= row_q + 1'b1;
			end else if (cmd.mark_init) begin
				row_q <= start[BLK_W-1:3];
			end
			if (cmd.scan_init) begin
				run_q <= '0;
			end else if (cmd.scan_ev) begin
				run_q <= run_n;
			end
			if (cmd.scan_ev && hit) begin
				end_q <= end_n;
			end
		end
	end

	// bitmap store, cleared by a sweep after reset
	assign ram_we = cmd.clr_we || cmd.mark_wr;
	assign wdata  = cmd.clr_we ? '0 : (rdata | mask);

	bffa_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (MAP_ROWS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (row_q),
		.wdata (wdata),
		.raddr (row_q),
		.rdata (rdata)
	);

	// result and output word
	always_ff @(posedge clk) begin
		if (cmd.set_ok) begin
			res_ok_q    <= 1'b1;
			res_start_q <= START_W'(start);
		end else if (cmd.set_zero) begin
			res_ok_q    <= 1'b1;
			res_start_q <= '0;
		end else if (cmd.set_fail) begin
			res_ok_q    <= 1'b0;
			res_start_q <= '0;
		end
		if (cmd.out_load) begin
			success_q     <= res_ok_q;
			start_block_q <= res_start_q;
		end
	end

	assign success     = success_q;
	assign start_block = start_block_q;

endmodule

`default_nettype wire

>>> hdl/bffa_ctrl.sv
`default_nettype none

module bffa_ctrl
	import bffa_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output      logic       in_stall,
	output      logic       out_valid,
	input  wire logic       out_stall,
	input  wire bffa_stat_t stat,
	output      bffa_cmd_t  cmd
);

	typedef enum logic [9:0] {
		S_CLEAR     = 10'b00_0000_0001,
		S_IDLE      = 10'b00_0000_0010,
		S_DIV       = 10'b00_0000_0100,
		S_CHECK     = 10'b00_0000_1000,
		S_SCAN_RD   = 10'b00_0001_0000,
		S_SCAN_EV   = 10'b00_0010_0000,
		S_MARK_INIT = 10'b00_0100_0000,
		S_MARK_RD   = 10'b00_1000_0000,
		S_MARK_WR   = 10'b01_0000_0000,
		S_DONE      = 10'b10_0000_0000
	} bffa_state_t;

	bffa_state_t state_q;
	bffa_state_t state_n;
	logic        out_valid_q;
	logic        out_free;

	assign out_free = !out_valid_q || !out_stall;

	// next state and commands
	always_comb begin
		state_n = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_we = 1'b1;
				if (stat.clr_last) begin
					state_n = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_n  = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_n = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.scan_init = 1'b1;
				priority if (stat.need_zero) begin
					cmd.set_zero = 1'b1;
					state_n      = S_DONE;
				end else if (stat.too_big) begin
					cmd.set_fail = 1'b1;
					state_n      = S_DONE;
				end else begin
					state_n = S_SCAN_RD;
				end
			end
			S_SCAN_RD: begin
				state_n = S_SCAN_EV;
			end
			S_SCAN_EV: begin
				cmd.scan_ev = 1'b1;
				priority if (stat.scan_hit) begin
					state_n = S_MARK_INIT;
				end else if (stat.scan_last) begin
					cmd.set_fail = 1'b1;
					state_n      = S_DONE;
				end else begin
					state_n = S_SCAN_RD;
				end
			end
			S_MARK_INIT: begin
				cmd.mark_init = 1'b1;
				state_n       = S_MARK_RD;
			end
			S_MARK_RD: begin
				state_n = S_MARK_WR;
			end
			S_MARK_WR: begin
				cmd.mark_wr = 1'b1;
				if (stat.mark_last) begin
					cmd.set_ok = 1'b1;
					state_n    = S_DONE;
				end else begin
					state_n = S_MARK_RD;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_n      = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	// state and output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

>>> hdl/bitmap_first_fit_block_allocator.sv
`default_nettype none

// First-fit block allocator over an occupancy bitmap of MAX_BLOCKS bits held in a
// byte-wide RAM. Each request word is rounded up to whole blocks by a restoring
// divider, then the bitmap is scanned from block 0 one byte at a time, a read state
// and an evaluate state per byte, until a free run is found or the pool ends, and
// the run is marked by read-modify-write of each byte it covers. A zero-byte or
// oversize request skips the scan. A finished result is held back while the output
// word is stalled. One request is worked on at a time; a finished result waits in
// the output register while the next request word is taken. After reset the bitmap
// is cleared by a sweep over every byte during which no request is taken;
// configuration writes are always ready and must only be made while the block is idle.
module bitmap_first_fit_block_allocator
	import bffa_pkg::*;
#(
	parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output      logic                  in_stall,
	input  wire logic [REQ_W-1:0]      request_bytes,
	output      logic                  out_valid,
	input  wire logic                  out_stall,
	output      logic                  success,
	output      logic [START_W-1:0]    start_block,
	input  wire logic                  cfg_valid,
	output      logic                  cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	bffa_cmd_t  cmd;
	bffa_stat_t stat;

	assign cfg_ready = 1'b1;

	// sequencer
	bffa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// divider, bitmap and result registers
	bffa_dp #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.request_bytes (request_bytes),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.success       (success),
		.start_block   (start_block)
	);

`ifndef SYNTHESIS
	// an accepted request keeps the input side closed until it completes
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken again straight after a request");

	// a failed allocation reports block zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !success) |-> (start_block == '0))
		else $error("failed allocation with nonzero start block");

	// the bitmap is only written while a request or the clear sweep is in progress
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.clr_we || cmd.mark_wr) |-> in_stall)
		else $error("bitmap written while idle");

	// a new output word is loaded only when the output register can take it
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || !out_stall))
		else $error("output word overwritten while stalled");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
	import bffa_pkg::*;

	localparam int MAX_BLOCKS = DEF_MAX_BLOCKS;
	localparam int RAND_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 200;
	localparam int LONG_HOLD_AT = 300;
	localparam int LONG_HOLD_CYCLES = 600;

	// one expected allocation outcome
	typedef struct packed {
		logic               ok;
		logic [START_W-1:0] first;
	} grant_t;

	// tracks register settings and block occupancy, predicts each grant
	class pool_scoreboard;
		bit [BS_W-1:0] blk_size;
		bit [NB_W-1:0] blk_count;
		bit            used [MAX_BLOCKS];
		grant_t        grants_due [$];
		int            mismatches;

		function new();
			blk_size = BS_RESET;
			blk_count = NB_RESET;
			foreach (used[i]) used[i] = 1'b0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_BLOCK_SIZE: begin
					blk_size = data[BS_W-1:0];
				end
				REG_NUM_BLOCKS: begin
					blk_count = data[NB_W-1:0];
				end
				default: begin
				end
			endcase
		endfunction

		// first-fit search from block 0, marks the run on a hit
		function void note_request(logic [REQ_W-1:0] req);
			longint unsigned bs;
			longint unsigned need;
			int unsigned     pool;
			int unsigned     run;
			int unsigned     start;
			bit              found;
			grant_t          g;
			bs = (blk_size == 0) ? 64'd1 : 64'(blk_size);
			need = (64'(req) + bs - 64'd1) / bs;
			pool = (blk_count > MAX_BLOCKS) ? MAX_BLOCKS : blk_count;
			run = 0;
			start = 0;
			found = 1'b0;
			g = '0;
			if (need == 0) begin
				g.ok = 1'b1;
			end else if (need <= 64'(pool)) begin
				for (int unsigned i = 0; i < pool && !found; i++) begin
					if (used[i]) begin
						run = 0;
					end else begin
						run++;
						if (64'(run) == need) begin
							start = i + 1 - run;
							found = 1'b1;
						end
					end
				end
				if (found) begin
					for (int unsigned i = start; i < start + run; i++) used[i] = 1'b1;
					g.ok = 1'b1;
					g.first = start[START_W-1:0];
				end
			end
			grants_due.push_back(g);
		endfunction

		function void check_grant(logic ok, logic [START_W-1:0] first);
			grant_t g;
			if (grants_due.size() == 0) begin
				$error("unexpected result word: success=%0d start_block=%0d", ok, first);
				mismatches++;
			end else begin
				g = grants_due.pop_front();
				if (ok !== g.ok) begin
					$error("success: expected %0d, got %0d", g.ok, ok);
					mismatches++;
				end
				if (first !== g.first) begin
					$error("start_block: expected %0d, got %0d", g.first, first);
					mismatches++;
				end
			end
		endfunction

		function int outstanding();
			return grants_due.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [REQ_W-1:0]      request_bytes;
	logic                  out_valid;
	logic                  out_stall;
	logic                  success;
	logic [START_W-1:0]    start_block;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pool_scoreboard sb = new();
	bit             tx_eager;
	bit             rx_eager;
	int             words_done;

	int rnd_bs [RAND_PHASES] = '{1, 0, 64, 256, 1000, 4096, 65536, 131071};
	int rnd_nb [RAND_PHASES] = '{24, 40, 64, 96, 128, 180, 257, 256};

	bitmap_first_fit_block_allocator #(
		.MAX_BLOCKS(MAX_BLOCKS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.request_bytes(request_bytes),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.success(success),
		.start_block(start_block),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// note accepted request words and check result words
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) sb.note_request(request_bytes);
		if (arst_n && out_valid && !out_stall) sb.check_grant(success, start_block);
	end

	// result side: random stalls, one long hold-off to back the block up
	initial begin
		int n;
		out_stall = 1'b0;
		words_done = 0;
		rx_eager = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (words_done % 50 == 0) rx_eager = ($urandom_range(0, 2) == 0);
			n = rx_eager ? 0 : $urandom_range(0, 15);
			if (words_done == LONG_HOLD_AT) n = LONG_HOLD_CYCLES;
			if (n != 0) begin
				out_stall = 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall = 1'b0;
			do @(posedge clk); while (!out_valid);
			words_done++;
			@(negedge clk);
		end
	end

	// offer one request word, return once it is taken
	task automatic send_request(input logic [REQ_W-1:0] req);
		int gap;
		gap = tx_eager ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		request_bytes = req;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// wait until every expected result word has come back
	task automatic drain();
		while (sb.outstanding() != 0) @(negedge clk);
	endtask

	task automatic set_pool(input int bs, input int nb);
		drain();
		write_cfg(REG_BLOCK_SIZE, CFG_DATA_W'(bs));
		// upper data bits carry noise, only the low bits count
		write_cfg(REG_NUM_BLOCKS, {8'($urandom_range(0, 255)), NB_W'(nb)});
	endtask

	// mostly well-formed sizes near the free space, some boundaries and noise
	function automatic logic [REQ_W-1:0] pick_request(longint unsigned bs, int pool);
		int              kind;
		longint unsigned need;
		longint unsigned req;
		kind = $urandom_range(0, 99);
		if (kind < 55) need = $urandom_range(1, 4);
		else need = $urandom_range(1, pool + 8);
		req = (need - 1) * bs + 64'($urandom_range(1, int'(bs)));
		if (kind >= 75 && kind < 83) req = 0;
		else if (kind >= 83 && kind < 90) req = need * bs + 64'($urandom_range(0, 1));
		else if (kind >= 90) req = 64'($urandom);
		return req[REQ_W-1:0];
	endfunction

	initial begin
		int bs;
		int nb;
		arst_n = 1'b0;
		in_valid = 1'b0;
		request_bytes = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		tx_eager = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// unknown register index, then empty pool with zero block size
		write_cfg(8'hFF, 17'h1FFFF);
		set_pool(0, 0);
		send_request(32'd0);
		send_request(32'd1);
		send_request(32'hFFFF_FFFF);

		// largest block size, pool size above the maximum
		set_pool(131071, 511);
		send_request(32'hFFFF_FFFF);
		send_request(32'd1);
		send_request(32'd131071);
		send_request(32'd131072);
		send_request(32'd0);

		// byte-sized blocks: no run long enough, exact fit, pool full
		set_pool(1, 8);
		send_request(32'd5);
		send_request(32'd4);
		send_request(32'd1);

		// single-block pool already taken, and too large for it
		set_pool(65536, 1);
		send_request(32'd0);
		send_request(32'd65536);
		send_request(32'd65537);

		// reset values back, a multi-byte run past the used area
		set_pool(256, 256);
		send_request(32'd2305);
		send_request(32'd255);
		send_request(32'h8000_0000);

		// random phases, pool growing so fresh blocks open up
		for (int p = 0; p < RAND_PHASES; p++) begin
			bs = rnd_bs[p];
			nb = rnd_nb[p];
			if (p == 4) bs = $urandom_range(1, 131071);
			set_pool(bs, nb);
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				if (k % 40 == 0) tx_eager = ($urandom_range(0, 2) == 0);
				send_request(pick_request((bs == 0) ? 1 : bs, (nb > MAX_BLOCKS) ? MAX_BLOCKS : nb));
			end
		end

		drain();
		repeat (150) @(posedge clk);
		if (sb.mismatches == 0 && sb.outstanding() == 0) begin
			$display("bitmap_first_fit_block_allocator regression: pass");
		end else begin
			$display("bitmap_first_fit_block_allocator regression: fail");
		end
		$finish;
	end

	// overall watchdog
	initial begin
		#5_000_000;
		$display("bitmap_first_fit_block_allocator regression: fail");
		$finish;
	end

endmodule

>>> files.f
hdl/bffa_pkg.sv
hdl/bffa_ram.sv
hdl/bffa_div.sv
hdl/bffa_dp.sv
hdl/bffa_ctrl.sv
hdl/bitmap_first_fit_block_allocator.sv
tb/sv/tb.sv
